/* hdl/sph_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sph_pkg;

   // SipHash initialization constants
   localparam logic [63:0] SPH_C0 = 64'h736f_6d65_7073_6575;
   localparam logic [63:0] SPH_C1 = 64'h646f_7261_6e64_6f6d;
   localparam logic [63:0] SPH_C2 = 64'h6c79_6765_6e65_7261;
   localparam logic [63:0] SPH_C3 = 64'h7465_6462_7974_6573;

   // Length block: 8 message bytes in the top byte
   localparam logic [63:0] SPH_LEN_WORD   = 64'h0800_0000_0000_0000;
   localparam logic [63:0] SPH_FINAL_MASK = 64'h0000_0000_0000_00ff;

   // Two half rounds per SipRound, eight SipRounds in total
   localparam int SPH_HALF_STAGES   = 16;
   // Half-round stage that opens the length block (after two rounds)
   localparam int SPH_LEN_STAGE     = 4;
   // Half-round stage that opens finalization (after four rounds)
   localparam int SPH_FINAL_STAGE   = 8;

   typedef struct packed {
      logic [63:0] v0;
      logic [63:0] v1;
      logic [63:0] v2;
      logic [63:0] v3;
   } sph_state_type;

   // Per-stage control, tied to constants at each stage
   typedef struct packed {
      logic second_half;  // second half of a SipRound
      logic mix_msg;      // v0 ^= message word (closes message block)
      logic mix_len_v3;   // v3 ^= length word (opens length block)
      logic mix_len_v0;   // v0 ^= length word (closes length block)
      logic mix_final;    // v2 ^= 0xff (opens finalization)
   } sph_stage_ctl_type;

   // 32-bit word repeated into 64 bits
   function automatic logic [63:0] sph_double(input logic [31:0] w);
      return {w, w};
   endfunction

   // First half of a SipRound: two independent adds
   function automatic sph_state_type sph_half_first(input sph_state_type s);
      sph_state_type r;
      logic [63:0]   a0;
      logic [63:0]   a2;
      a0   = s.v0 + s.v1;
      a2   = s.v2 + s.v3;
      r.v1 = {s.v1[50:0], s.v1[63:51]} ^ a0;   // rotl 13
      r.v0 = {a0[31:0], a0[63:32]};            // rotl 32
      r.v3 = {s.v3[47:0], s.v3[63:48]} ^ a2;   // rotl 16
      r.v2 = a2;
      return r;
   endfunction

   // Second half of a SipRound: two independent adds
   function automatic sph_state_type sph_half_second(input sph_state_type s);
      sph_state_type r;
      logic [63:0]   a0;
      logic [63:0]   a2;
      a0   = s.v0 + s.v3;
      a2   = s.v2 + s.v1;
      r.v3 = {s.v3[42:0], s.v3[63:43]} ^ a0;   // rotl 21
      r.v0 = a0;
      r.v1 = {s.v1[46:0], s.v1[63:47]} ^ a2;   // rotl 17
      r.v2 = {a2[31:0], a2[63:32]};            // rotl 32
      return r;
   endfunction

   // Control word for half-round stage h
   function automatic sph_stage_ctl_type sph_stage_ctl(input int h);
      sph_stage_ctl_type c;
      c.second_half = ((h % 2) == 1);
      c.mix_msg     = (h == SPH_LEN_STAGE);
      c.mix_len_v3  = (h == SPH_LEN_STAGE);
      c.mix_len_v0  = (h == SPH_FINAL_STAGE);
      c.mix_final   = (h == SPH_FINAL_STAGE);
      return c;
   endfunction

endpackage

`default_nettype wire

/* hdl/siphash24_keyed_prf_32bit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Keyed 32-bit PRF built on SipHash-2-4. The 32-bit key (csr_prf_key) is
// repeated into both 64-bit key words, each 32-bit req_value_in is repeated
// into one 8-byte message word, and rsp_prf_out returns the low 32 bits of
// the 64-bit tag. Results come back in request order. One transaction is
// accepted every cycle while req_stall is low. The path is a key/message
// setup register, sixteen half-SipRound stages (one 64-bit add level each,
// eight rounds in all) and a tag fold register. Each stage holds under
// rsp_stall, so req_stall rises only once every stage is full. The key is
// sampled when a transaction enters; write it only while the pipeline is
// empty.
module siphash24_keyed_prf_32bit
   import sph_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // key register
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [31:0]   csr_prf_key,
   // request channel
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [31:0]   req_value_in,
   // response channel
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [31:0]        rsp_prf_out
);

   // index 0 is the setup stage, 1..16 the half-round stages
   logic          [SPH_HALF_STAGES:0] stage_valid;
   logic          [SPH_HALF_STAGES:0] stage_ready;
   sph_state_type                     stage_state [0:SPH_HALF_STAGES];
   logic          [31:0]              stage_value [0:SPH_HALF_STAGES];
   logic                              entry_ready;

   // key register and initial state
   sph_entry u_entry (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_prf_key (csr_prf_key),
      .in_valid    (req_valid),
      .in_ready    (entry_ready),
      .in_value    (req_value_in),
      .out_valid   (stage_valid[0]),
      .out_ready   (stage_ready[0]),
      .out_state   (stage_state[0]),
      .out_value   (stage_value[0])
   );

   assign req_stall = !entry_ready;

   // eight SipRounds as sixteen half-round stages
   for (genvar h = 0; h < SPH_HALF_STAGES; h++) begin : g_half
      sph_half_round u_half (
         .clock     (clock),
         .reset     (reset),
         .stage_ctl (sph_stage_ctl(h)),
         .in_valid  (stage_valid[h]),
         .in_ready  (stage_ready[h]),
         .in_state  (stage_state[h]),
         .in_value  (stage_value[h]),
         .out_valid (stage_valid[h+1]),
         .out_ready (stage_ready[h+1]),
         .out_state (stage_state[h+1]),
         .out_value (stage_value[h+1])
      );
   end

   // tag fold and output register
   sph_tag u_tag (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[SPH_HALF_STAGES]),
      .in_ready  (stage_ready[SPH_HALF_STAGES]),
      .in_state  (stage_state[SPH_HALF_STAGES]),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_tag   (rsp_prf_out)
   );

   // requests are only held back when the whole pipeline is full
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&stage_valid) && rsp_valid)
      else $error("request stalled with a bubble in the pipeline");

   // a free output never backs up into the request side
   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && (stage_valid == '0))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

/* hdl/sph_entry.sv */
`timescale 1ns / 1ps
`default_nettype none

module sph_entry
   import sph_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   // key register write
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [31:0]   csr_prf_key,
   // incoming transaction
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [31:0]   in_value,
   // to first half-round stage
   output logic               out_valid,
   input  wire logic          out_ready,
   output sph_state_type      out_state,
   output logic [31:0]        out_value
);

   logic          key_write;
   logic [31:0]   prf_key_ff;
   logic          valid_ff;
   logic          valid_in;
   logic          advance;
   sph_state_type state_ff;
   sph_state_type state_in;
   logic [31:0]   value_ff;
   logic [63:0]   key_word;

   // key register, always writable
   assign csr_ready = 1'b1;
   assign key_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prf_key_ff <= '0;
      end else if (key_write) begin
         prf_key_ff <= csr_prf_key;
      end
   end

   // stage moves when empty or when the next one takes its contents
   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // initial state, message word folded into v3
   always_comb begin
      key_word    = sph_double(prf_key_ff);
      state_in.v0 = key_word ^ SPH_C0;
      state_in.v1 = key_word ^ SPH_C1;
      state_in.v2 = key_word ^ SPH_C2;
      state_in.v3 = key_word ^ SPH_C3 ^ sph_double(in_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         state_ff <= state_in;
         value_ff <= in_value;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_value = value_ff;

endmodule

`default_nettype wire

/* hdl/sph_half_round.sv */
`timescale 1ns / 1ps
`default_nettype none

module sph_half_round
   import sph_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sph_stage_ctl_type  stage_ctl,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire sph_state_type      in_state,
   input  wire logic [31:0]        in_value,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output sph_state_type           out_state,
   output logic [31:0]             out_value
);

   logic          valid_ff;
   logic          valid_in;
   logic          advance;
   sph_state_type mixed;
   sph_state_type state_ff;
   sph_state_type state_in;
   logic [31:0]   value_ff;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // block boundary injections, then one half round
   always_comb begin
      mixed = in_state;
      if (stage_ctl.mix_msg) begin
         mixed.v0 = mixed.v0 ^ sph_double(in_value);
      end
      if (stage_ctl.mix_len_v3) begin
         mixed.v3 = mixed.v3 ^ SPH_LEN_WORD;
      end
      if (stage_ctl.mix_len_v0) begin
         mixed.v0 = mixed.v0 ^ SPH_LEN_WORD;
      end
      if (stage_ctl.mix_final) begin
         mixed.v2 = mixed.v2 ^ SPH_FINAL_MASK;
      end
      state_in = stage_ctl.second_half ? sph_half_second(mixed) : sph_half_first(mixed);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         state_ff <= state_in;
         value_ff <= in_value;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;
   assign out_value = value_ff;

   // a held transaction keeps its state until the next stage takes it
   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(state_ff))
      else $error("half-round stage lost its state while stalled");

endmodule

`default_nettype wire

/* hdl/sph_tag.sv */
`timescale 1ns / 1ps
`default_nettype none

module sph_tag
   import sph_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire sph_state_type  in_state,
   output logic                out_valid,
   input  wire logic           out_stall,
   output logic [31:0]         out_tag
);

   logic        valid_ff;
   logic        valid_in;
   logic        advance;
   logic [63:0] tag_full;
   logic [31:0] tag_ff;

   assign advance  = !valid_ff || !out_stall;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // fold the four lanes, keep the low half
   assign tag_full = in_state.v0 ^ in_state.v1 ^ in_state.v2 ^ in_state.v3;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         tag_ff <= tag_full[31:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_tag   = tag_ff;

endmodule

`default_nettype wire

/* dv/siphash24_keyed_prf_32bit_tb.sv */
`timescale 1ns / 1ps

module siphash24_keyed_prf_32bit_tb;
   import sph_pkg::*;

   // four 64-bit lanes of the SipHash state
   typedef struct packed {
      bit [63:0] v0;
      bit [63:0] v1;
      bit [63:0] v2;
      bit [63:0] v3;
   } hash_lanes_type;

   // Tracks the key, predicts each tag and compares the responses in order
   class prf_scoreboard;
      bit [31:0] key;
      bit [31:0] expected_tags[$];
      int        mismatches;
      int        unexpected;
      int        values_seen;
      int        tags_seen;

      function new();
         key         = '0;
         mismatches  = 0;
         unexpected  = 0;
         values_seen = 0;
         tags_seen   = 0;
      endfunction

      function bit [63:0] rotl64(bit [63:0] x, int unsigned s);
         return (x << s) | (x >> (64 - s));
      endfunction

      function hash_lanes_type sip_round(hash_lanes_type s);
         s.v0 += s.v1; s.v1 = rotl64(s.v1, 13); s.v1 ^= s.v0; s.v0 = rotl64(s.v0, 32);
         s.v2 += s.v3; s.v3 = rotl64(s.v3, 16); s.v3 ^= s.v2;
         s.v0 += s.v3; s.v3 = rotl64(s.v3, 21); s.v3 ^= s.v0;
         s.v2 += s.v1; s.v1 = rotl64(s.v1, 17); s.v1 ^= s.v2; s.v2 = rotl64(s.v2, 32);
         return s;
      endfunction

      // one compression block: two rounds between the XORs
      function hash_lanes_type mix_block(hash_lanes_type s, bit [63:0] word);
         s.v3 ^= word;
         s = sip_round(s);
         s = sip_round(s);
         s.v0 ^= word;
         return s;
      endfunction

      // SipHash-2-4 over one doubled word under the doubled key, low half of tag
      function bit [31:0] keyed_tag(bit [31:0] value);
         hash_lanes_type s;
         bit [63:0]      kw;
         bit [63:0]      tag;
         kw   = {key, key};
         s.v0 = kw ^ SPH_C0;
         s.v1 = kw ^ SPH_C1;
         s.v2 = kw ^ SPH_C2;
         s.v3 = kw ^ SPH_C3;
         s    = mix_block(s, {value, value});
         s    = mix_block(s, SPH_LEN_WORD);
         s.v2 ^= SPH_FINAL_MASK;
         repeat (4) s = sip_round(s);
         tag  = s.v0 ^ s.v1 ^ s.v2 ^ s.v3;
         return tag[31:0];
      endfunction

      function void set_key(bit [31:0] k);
         key = k;
      endfunction

      function void note_value(bit [31:0] value);
         expected_tags.push_back(keyed_tag(value));
         values_seen++;
      endfunction

      function void check_tag(bit [31:0] actual);
         bit [31:0] want;
         tags_seen++;
         if (expected_tags.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: response %08h with no transaction outstanding", actual);
            return;
         end
         want = expected_tags.pop_front();
         if (want !== actual) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
               $display("ERROR: prf_out expected %08h actual %08h (response %0d)",
                        want, actual, tags_seen);
         end
      endfunction

      function int pending();
         return expected_tags.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_prf_key = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_prf_out;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int key_writes = 0;

   prf_scoreboard sb = new();

   siphash24_keyed_prf_32bit i_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_prf_key  (csr_prf_key),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_value_in (req_value_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_prf_out  (rsp_prf_out)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver: long hold-off when requested, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(1, 100) <= recv_stall_pct);
      end
   end

   // monitor both channels on the clock edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            sb.note_value(req_value_in);
         if (rsp_valid && !rsp_stall)
            sb.check_tag(rsp_prf_out);
      end
   end

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic send_value(input bit [31:0] value);
      while ($urandom_range(1, 100) <= send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_value_in <= value;
      do @(posedge clock); while (req_stall);
   endtask

   // wait until every transaction in flight has returned
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0)
         @(posedge clock);
   endtask

   task automatic write_key(input bit [31:0] k);
      csr_valid   <= 1'b1;
      csr_prf_key <= k;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_key(k);
      key_writes++;
   endtask

   function automatic bit [31:0] random_value();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         2:       return 32'h1 << $urandom_range(0, 31);
         3:       return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   bit [31:0] corner_values[12] = '{
      32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
      32'h7fff_ffff, 32'h0000_ffff, 32'hffff_0000, 32'haaaa_aaaa,
      32'h5555_5555, 32'h1234_5678, 32'hdead_beef, 32'hfffe_ffff
   };

   initial begin
      bit [31:0] k;
      int        phase_send[3];
      int        phase_recv[3];

      phase_send = '{11, 76, 0};
      phase_recv = '{76, 11, 0};

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct  = phase_send[0];
      recv_stall_pct = phase_recv[0];

      // corner values under the reset key, then under the all-ones key
      foreach (corner_values[i]) send_value(corner_values[i]);
      drain();
      write_key(32'hffff_ffff);
      foreach (corner_values[i]) send_value(corner_values[i]);

      // random values, three idle profiles, three keys each
      for (int p = 0; p < 3; p++) begin
         send_idle_pct  = phase_send[p];
         recv_stall_pct = phase_recv[p];
         for (int c = 0; c < 3; c++) begin
            case (p * 3 + c)
               0:       k = 32'h0000_0001;
               3:       k = 32'h8000_0000;
               4:       k = 32'h0000_0000;
               8:       k = 32'hffff_ffff;
               default: k = $urandom;
            endcase
            drain();
            write_key(k);
            // long output hold-off so the pipeline fills and backs up
            if (p == 2 && c == 0)
               hold_left = 150;
            repeat (111) send_value(random_value());
         end
      end

      drain();
      repeat (25) @(posedge clock);

      $display("Hashed %0d values under %0d key writes, %0d tags returned;",
               sb.values_seen, key_writes, sb.tags_seen);
      $display("input gaps, output stalls and a full-pipeline hold-off were exercised.");
      if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing",
                  sb.mismatches, sb.unexpected, sb.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/sph_pkg.sv
hdl/sph_entry.sv
hdl/sph_half_round.sv
hdl/sph_tag.sv
hdl/siphash24_keyed_prf_32bit.sv
dv/siphash24_keyed_prf_32bit_tb.sv
